@@ src/cvrt_pkg.sv @@
// ----------------------------------------------------------------------------
// cvrt_pkg: shared types and constants of the circle visit tracker
// Operand widths, control structs and small helpers used by the sequencer
// and by its shared arithmetic units.
// ----------------------------------------------------------------------------
package cvrt_pkg;

	localparam int FRAC_BITS = 8;
	localparam int COORD_W   = 32;
	localparam int STAMP_W   = 32;
	localparam int TIME_W    = STAMP_W + FRAC_BITS;
	localparam int P_W       = FRAC_BITS + 1;
	localparam int CNT_W     = $clog2(FRAC_BITS + 2);
	localparam int RAD_W     = 31;
	localparam int RR_W      = 2 * RAD_W;
	localparam int MAG_W     = 32;
	localparam int MUL_W     = 66;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DISC_W    = 128;
	localparam int ROOT_W    = DISC_W / 2;
	localparam int SUM_W     = MUL_W + 2;
	localparam int REM_W     = ROOT_W + 4;
	localparam int NB_W      = 7;
	localparam int RES_W     = 48;
	localparam int VIS_W     = 32;
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_GAP  = 3'd3;

	localparam logic [NB_W-1:0] NB_SHORT = NB_W'(MAG_W);
	localparam logic [NB_W-1:0] NB_LONG  = NB_W'(MUL_W);

	typedef struct packed {
		logic            start;
		logic [NB_W-1:0] nbits;
	} mul_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} smag_t;

	// Sign and magnitude of a - b; the magnitude always fits 32 bits.
	function automatic smag_t diff_mag(input logic signed [COORD_W-1:0] a,
	                                   input logic signed [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		logic [COORD_W:0] n;
		smag_t r;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		n = -d;
		r.neg = d[COORD_W];
		r.mag = d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
		return r;
	endfunction

	// Signed value of a product magnitude.
	function automatic logic signed [SUM_W-1:0] signed_prod(input logic neg,
	                                                       input logic [MUL_W-1:0] p);
		logic signed [SUM_W-1:0] m;
		m = $signed({2'b00, p});
		return neg ? -m : m;
	endfunction

endpackage

@@ src/circle_visit_residence_tracker.sv @@
// Work per point: a point with no boundary crossing needs three 32-step
// products on the shared multiplier; a crossing point needs nine 32-step and
// two 66-step products, a 64-step square root and at most one 8-step
// fraction division. One point is in work at a time.
// A result waits in an output register while the next point is taken.
// Reset sets the pass state to the start of a pass and clears the registers.
// ----------------------------------------------------------------------------
// circle_visit_residence_tracker: visit count and residence time in a circle
// Tests each trajectory point against the circle, interpolates crossing
// times and accumulates visits and time inside until the last point.
// ----------------------------------------------------------------------------
module circle_visit_residence_tracker import cvrt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [STAMP_W-1:0]        stamp,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [VIS_W-1:0]          visit_count,
	output logic [RES_W-1:0]          residence_time
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MUL    = 6'b000010,
		S_DECIDE = 6'b000100,
		S_SQRT   = 6'b001000,
		S_DIV    = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		M_DX   = 4'd0,
		M_DY   = 4'd1,
		M_RR   = 4'd2,
		M_BX   = 4'd3,
		M_BY   = 4'd4,
		M_AXBX = 4'd5,
		M_AYBY = 4'd6,
		M_AXBY = 4'd7,
		M_AYBX = 4'd8,
		M_RD   = 4'd9,
		M_CC   = 4'd10
	} mstep_t;

	// Configuration registers.
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [RAD_W-1:0]          rad_q;
	logic [STAMP_W-1:0]        gap_q;

	// Current point.
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q;
	logic [STAMP_W-1:0]        cur_t_q;
	logic                      cur_last_q;

	// Pass state.
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic [STAMP_W-1:0]        prev_t_q;
	logic                      inside_q, first_q, exited_q;
	logic [TIME_W-1:0]         enter_q, leave_q;
	logic [VIS_W-1:0]          visits_q;
	logic [RES_W-1:0]          res_q;

	// Working registers.
	state_t                  state_q;
	mstep_t                  mstep_q;
	logic                    mul_go_q, sqrt_go_q;
	logic                    in_now_q;
	logic signed [SUM_W-1:0] acc_q, dot_q;
	logic [RR_W-1:0]         rr_q;
	logic [MUL_W-1:0]        d2_q, crs_mag_q;
	logic [DISC_W-1:0]       rd_q;
	logic [P_W-1:0]          p_q;
	logic [SUM_W-1:0]        rem_q;
	logic [CNT_W-1:0]        qcnt_q;
	smag_t                   ax_q, ay_q, bx_q, by_q;

	logic                    out_valid_q;
	logic [VIS_W-1:0]        out_cnt_q;
	logic [RES_W-1:0]        out_res_q;

	// Unit connections.
	mul_req_t          mul_req;
	unit_rsp_t         mul_rsp, sqrt_rsp;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod;
	logic [ROOT_W-1:0] root;

	smag_t dx_w, dy_w;

	always_comb begin
		dx_w = diff_mag(cur_x_q, cx_q);
		dy_w = diff_mag(cur_y_q, cy_q);
		mul_a = '0;
		mul_b = '0;
		mul_req.start = mul_go_q;
		mul_req.nbits = NB_SHORT;
		unique case (mstep_q)
			M_DX: begin
				mul_a = MUL_W'(dx_w.mag);
				mul_b = MUL_W'(dx_w.mag);
			end
			M_DY: begin
				mul_a = MUL_W'(dy_w.mag);
				mul_b = MUL_W'(dy_w.mag);
			end
			M_RR: begin
				mul_a = MUL_W'(rad_q);
				mul_b = MUL_W'(rad_q);
			end
			M_BX: begin
				mul_a = MUL_W'(bx_q.mag);
				mul_b = MUL_W'(bx_q.mag);
			end
			M_BY: begin
				mul_a = MUL_W'(by_q.mag);
				mul_b = MUL_W'(by_q.mag);
			end
			M_AXBX: begin
				mul_a = MUL_W'(ax_q.mag);
				mul_b = MUL_W'(bx_q.mag);
			end
			M_AYBY: begin
				mul_a = MUL_W'(ay_q.mag);
				mul_b = MUL_W'(by_q.mag);
			end
			M_AXBY: begin
				mul_a = MUL_W'(ax_q.mag);
				mul_b = MUL_W'(by_q.mag);
			end
			M_AYBX: begin
				mul_a = MUL_W'(ay_q.mag);
				mul_b = MUL_W'(bx_q.mag);
			end
			M_RD: begin
				mul_a = MUL_W'(rr_q);
				mul_b = d2_q;
				mul_req.nbits = NB_LONG;
			end
			M_CC: begin
				mul_a = crs_mag_q;
				mul_b = crs_mag_q;
				mul_req.nbits = NB_LONG;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	cvrt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (mul_a),
		.b      (mul_b),
		.rsp    (mul_rsp),
		.prod   (prod)
	);

	cvrt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_go_q),
		.n      (rd_q),
		.rsp    (sqrt_rsp),
		.root   (root)
	);

	// Combinational helpers of the multiply, root and division steps.
	logic [MUL_W-1:0]        p66;
	logic [MUL_W-1:0]        d2_sum;
	logic signed [SUM_W-1:0] crs_w, num_w;
	logic [PROD_W-1:0]       rd_ext;
	logic [SUM_W-1:0]        rem2;
	logic [SUM_W-1:0]        d2_ext;

	always_comb begin
		p66    = prod[MUL_W-1:0];
		d2_sum = acc_q[MUL_W-1:0] + p66;
		crs_w  = acc_q - signed_prod(ay_q.neg ^ bx_q.neg, p66);
		rd_ext = PROD_W'(rd_q);
		num_w  = dot_q + $signed(SUM_W'(root));
		rem2   = rem_q << 1;
		d2_ext = SUM_W'(d2_q);
	end

	// End-of-item update of the pass state.
	logic [STAMP_W-1:0] dt;
	logic [TIME_W:0]    pdt_full;
	logic [TIME_W-1:0]  pdt, now_t, prevt_f, leave_new, enter_new, enter_nxt, gap;
	logic [TIME_W-1:0]  res_from, res_to, res_d;
	logic               is_exit, is_entry, cnt_inc, add_res;
	logic [RES_W:0]     res_sum;
	logic [RES_W-1:0]   res_nxt;
	logic [VIS_W-1:0]   visits_nxt;
	logic               fin_go;
	logic               out_load;

	always_comb begin
		dt        = (cur_t_q >= prev_t_q) ? cur_t_q - prev_t_q : '0;
		pdt_full  = (TIME_W + 1)'(p_q) * (TIME_W + 1)'(dt);
		pdt       = pdt_full[TIME_W-1:0];
		now_t     = TIME_W'(cur_t_q) << FRAC_BITS;
		prevt_f   = TIME_W'(prev_t_q) << FRAC_BITS;
		is_exit   = !first_q && !in_now_q && inside_q;
		is_entry  = !first_q && in_now_q && !inside_q;
		leave_new = prevt_f + pdt;
		enter_new = now_t - pdt;
		gap       = (enter_new > leave_q) ? enter_new - leave_q : leave_q - enter_new;
		if (first_q && in_now_q) begin
			enter_nxt = now_t;
		end else if (is_entry) begin
			enter_nxt = enter_new;
		end else begin
			enter_nxt = enter_q;
		end
		cnt_inc = (first_q && in_now_q) ||
		          (is_entry && (!exited_q || gap > (TIME_W'(gap_q) << FRAC_BITS)));
		// An exit and ending inside never happen on the same point.
		add_res  = is_exit || (cur_last_q && in_now_q);
		res_from = is_exit ? enter_q : enter_nxt;
		res_to   = is_exit ? leave_new : now_t;
		res_d    = (add_res && res_to > res_from) ? res_to - res_from : '0;
		res_sum  = (RES_W + 1)'(res_q) + (RES_W + 1)'(res_d);
		res_nxt  = res_sum[RES_W] ? '1 : res_sum[RES_W-1:0];
		visits_nxt = (cnt_inc && visits_q != '1) ? visits_q + 1'b1 : visits_q;
		fin_go   = !cur_last_q || !out_valid_q || out_ready;
		out_load = (state_q == S_FIN) && fin_go && cur_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			rad_q <= '0;
			gap_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X: cx_q  <= $signed(cfg_data);
				REG_CENTER_Y: cy_q  <= $signed(cfg_data);
				REG_RADIUS:   rad_q <= cfg_data[RAD_W-1:0];
				REG_MAX_GAP:  gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstep_q     <= M_DX;
			mul_go_q    <= 1'b0;
			sqrt_go_q   <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_t_q     <= '0;
			cur_last_q  <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_t_q    <= '0;
			inside_q    <= 1'b0;
			first_q     <= 1'b1;
			exited_q    <= 1'b0;
			enter_q     <= '0;
			leave_q     <= '0;
			visits_q    <= '0;
			res_q       <= '0;
			in_now_q    <= 1'b0;
			acc_q       <= '0;
			dot_q       <= '0;
			rr_q        <= '0;
			d2_q        <= '0;
			crs_mag_q   <= '0;
			rd_q        <= '0;
			p_q         <= '0;
			rem_q       <= '0;
			qcnt_q      <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			bx_q        <= '0;
			by_q        <= '0;
			out_valid_q <= 1'b0;
			out_cnt_q   <= '0;
			out_res_q   <= '0;
		end else begin
			mul_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			if (out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_x_q    <= pos_x;
						cur_y_q    <= pos_y;
						cur_t_q    <= stamp;
						cur_last_q <= last;
						mstep_q    <= M_DX;
						mul_go_q   <= 1'b1;
						state_q    <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_rsp.done) begin
						mul_go_q <= 1'b1;
						unique case (mstep_q)
							M_DX: begin
								acc_q   <= signed_prod(1'b0, p66);
								mstep_q <= M_DY;
							end
							M_DY: begin
								acc_q   <= acc_q + signed_prod(1'b0, p66);
								mstep_q <= M_RR;
							end
							M_RR: begin
								in_now_q <= acc_q[MUL_W-1:0] <= p66;
								rr_q     <= prod[RR_W-1:0];
								mul_go_q <= 1'b0;
								state_q  <= S_DECIDE;
							end
							M_BX: begin
								acc_q   <= signed_prod(1'b0, p66);
								mstep_q <= M_BY;
							end
							M_BY: begin
								d2_q <= d2_sum;
								if (d2_sum == '0) begin
									// Zero-length segment: the crossing sits at its start.
									p_q      <= '0;
									mul_go_q <= 1'b0;
									state_q  <= S_FIN;
								end else begin
									mstep_q <= M_AXBX;
								end
							end
							M_AXBX: begin
								acc_q   <= signed_prod(ax_q.neg ^ bx_q.neg, p66);
								mstep_q <= M_AYBY;
							end
							M_AYBY: begin
								dot_q   <= acc_q + signed_prod(ay_q.neg ^ by_q.neg, p66);
								mstep_q <= M_AXBY;
							end
							M_AXBY: begin
								acc_q   <= signed_prod(ax_q.neg ^ by_q.neg, p66);
								mstep_q <= M_AYBX;
							end
							M_AYBX: begin
								crs_mag_q <= crs_w[SUM_W-1] ? MUL_W'(-crs_w) : MUL_W'(crs_w);
								mstep_q   <= M_RD;
							end
							M_RD: begin
								rd_q    <= prod[DISC_W-1:0];
								mstep_q <= M_CC;
							end
							M_CC: begin
								// A negative discriminant is clamped to zero.
								rd_q      <= (rd_ext >= prod) ? DISC_W'(rd_ext - prod) : '0;
								mul_go_q  <= 1'b0;
								sqrt_go_q <= 1'b1;
								state_q   <= S_SQRT;
							end
							default: begin
								mul_go_q <= 1'b0;
								state_q  <= S_IDLE;
							end
						endcase
					end
				end
				S_DECIDE: begin
					if (first_q || (in_now_q == inside_q)) begin
						state_q <= S_FIN;
					end else begin
						// Point A is inside the circle, point B outside.
						if (!in_now_q) begin
							ax_q <= diff_mag(cx_q, prev_x_q);
							ay_q <= diff_mag(cy_q, prev_y_q);
							bx_q <= diff_mag(cur_x_q, prev_x_q);
							by_q <= diff_mag(cur_y_q, prev_y_q);
						end else begin
							ax_q <= diff_mag(cx_q, cur_x_q);
							ay_q <= diff_mag(cy_q, cur_y_q);
							bx_q <= diff_mag(prev_x_q, cur_x_q);
							by_q <= diff_mag(prev_y_q, cur_y_q);
						end
						mstep_q  <= M_BX;
						mul_go_q <= 1'b1;
						state_q  <= S_MUL;
					end
				end
				S_SQRT: begin
					if (sqrt_rsp.done) begin
						if (num_w[SUM_W-1] || num_w == '0) begin
							p_q     <= '0;
							state_q <= S_FIN;
						end else if ($unsigned(num_w) >= d2_ext) begin
							p_q     <= P_W'(1) << FRAC_BITS;
							state_q <= S_FIN;
						end else begin
							rem_q   <= $unsigned(num_w);
							p_q     <= '0;
							qcnt_q  <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (qcnt_q == CNT_W'(FRAC_BITS)) begin
						state_q <= S_FIN;
					end else begin
						if (rem2 >= d2_ext) begin
							rem_q <= rem2 - d2_ext;
							p_q   <= {p_q[P_W-2:0], 1'b1};
						end else begin
							rem_q <= rem2;
							p_q   <= {p_q[P_W-2:0], 1'b0};
						end
						qcnt_q <= qcnt_q + 1'b1;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (cur_last_q) begin
							out_valid_q <= 1'b1;
							out_cnt_q   <= visits_nxt;
							out_res_q   <= res_nxt;
							prev_x_q    <= '0;
							prev_y_q    <= '0;
							prev_t_q    <= '0;
							inside_q    <= 1'b0;
							first_q     <= 1'b1;
							exited_q    <= 1'b0;
							enter_q     <= '0;
							leave_q     <= '0;
							visits_q    <= '0;
							res_q       <= '0;
						end else begin
							prev_x_q <= cur_x_q;
							prev_y_q <= cur_y_q;
							prev_t_q <= cur_t_q;
							inside_q <= in_now_q;
							first_q  <= 1'b0;
							enter_q  <= enter_nxt;
							visits_q <= visits_nxt;
							res_q    <= res_nxt;
							if (is_exit) begin
								leave_q  <= leave_new;
								exited_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign visit_count    = out_cnt_q;
	assign residence_time = out_res_q;

endmodule

@@ src/cvrt_mul.sv @@
// ----------------------------------------------------------------------------
// cvrt_mul: shared shift-and-add multiplier
// Unsigned product of two operands, one multiplier bit per cycle, for a
// requested number of multiplier bits.
// ----------------------------------------------------------------------------
module cvrt_mul import cvrt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mul_req_t          req,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output unit_rsp_t         rsp,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] a_q;
	logic [MUL_W-1:0]  b_q;
	logic [PROD_W-1:0] acc_q;
	logic [NB_W-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q    <= PROD_W'(a);
				b_q    <= b;
				acc_q  <= '0;
				cnt_q  <= req.nbits;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NB_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign prod     = acc_q;

endmodule

@@ src/cvrt_sqrt.sv @@
// ----------------------------------------------------------------------------
// cvrt_sqrt: digit-by-digit integer square root
// Floor of the square root of a 128-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module cvrt_sqrt import cvrt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DISC_W-1:0] n,
	output unit_rsp_t         rsp,
	output logic [ROOT_W-1:0] root
);

	logic [DISC_W-1:0] n_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [NB_W-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_s;
	logic [REM_W-1:0]  trial;

	always_comb begin
		rem_s = {rem_q[REM_W-3:0], n_q[DISC_W-1:DISC_W-2]};
		trial = REM_W'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q    <= n;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= NB_W'(ROOT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				n_q <= n_q << 2;
				if (rem_s >= trial) begin
					rem_q  <= rem_s - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_s;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NB_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign root     = root_q;

endmodule

@@ src/cvrt_checker.sv @@
// ----------------------------------------------------------------------------
// cvrt_checker: port-level checks of the circle visit tracker
// Watches the handshakes on the top level and flags broken sequencing.
// ----------------------------------------------------------------------------
module cvrt_checker import cvrt_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [VIS_W-1:0]          visit_count,
	input logic [RES_W-1:0]          residence_time
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(visit_count) && $stable(residence_time))
		else $error("stalled result item changed");

	// The sequencer is busy after it takes an item, so in_ready stays low.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input item taken while the previous one is in work");

	// A new result only appears at the end of the work on an item.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result item appeared while idle");

endmodule

bind circle_visit_residence_tracker cvrt_checker u_cvrt_checker (.*);
